FILE: hdl/sras_pkg.sv
// ----------------------------------------------------------------------------
// sras_pkg: shared types and constants for the sequence range add/sum unit
// Holds store geometry, request and error codes, payload structs and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sras_pkg;

	// Store geometry
	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int DATA_W       = 32;

	// Field widths of the request and result
	localparam int KIND_W  = 2;
	localparam int FIRST_W = 11;
	localparam int LAST_W  = 10;
	localparam int ERR_W   = 2;

	// Width that holds positions and the element count without loss
	localparam int CMP_W = (CNT_W > FIRST_W) ? CNT_W : FIRST_W;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM    = 2'd2;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
	localparam logic [ERR_W-1:0] ERR_SPAN = 2'd2;

	// Request payload
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [FIRST_W-1:0]        first_position;
		logic [LAST_W-1:0]         last_position;
		logic signed [DATA_W-1:0]  operand_value;
	} in_t;

	// Result payload
	typedef struct packed {
		logic signed [DATA_W-1:0]  range_total;
		logic [ERR_W-1:0]          error_code;
	} out_t;

	// Store access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Finished result handed to the output register
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] total;
		logic [ERR_W-1:0]  err;
	} res_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_PUT,
		ST_FINISH
	} state_t;

endpackage

FILE: hdl/sras_ram.sv
// ----------------------------------------------------------------------------
// sras_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sras_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/sras_seq.sv
// ----------------------------------------------------------------------------
// sras_seq: request sequencer for the sequence store
// Decodes a request, walks the store one element per cycle with a
// read-modify-write pipeline, and hands the finished result onward.
// ----------------------------------------------------------------------------
module sras_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sras_pkg::in_t                 in_data,
	output sras_pkg::mem_req_t            mem_req,
	input  logic [sras_pkg::DATA_W-1:0]   mem_rdata,
	input  logic                          out_free,
	output sras_pkg::res_t                res
);

	sras_pkg::state_t state_q, state_d;

	logic [sras_pkg::CNT_W-1:0]  count_q;
	logic [sras_pkg::ADDR_W-1:0] ptr_q;
	logic [sras_pkg::ADDR_W-1:0] end_q;
	logic [sras_pkg::KIND_W-1:0] kind_q;
	logic [sras_pkg::DATA_W-1:0] val_q;
	logic [sras_pkg::ERR_W-1:0]  err_q;
	logic [sras_pkg::DATA_W-1:0] total_q;
	logic                        v_s1;
	logic [sras_pkg::ADDR_W-1:0] addr_s1;

	// Request decode
	logic [sras_pkg::CMP_W-1:0]  lo_x, hi_x, cnt_x, at_x;
	logic [sras_pkg::CNT_W-1:0]  cnt_m1;
	logic                        full, span_ok;
	logic [sras_pkg::ERR_W-1:0]  dec_err;
	sras_pkg::state_t            dec_next;
	logic [sras_pkg::ADDR_W-1:0] dec_ptr, dec_end;
	logic                        accept;

	assign accept = in_valid && in_ready;
	assign lo_x   = sras_pkg::CMP_W'(in_data.first_position);
	assign hi_x   = sras_pkg::CMP_W'(in_data.last_position);
	assign cnt_x  = sras_pkg::CMP_W'(count_q);
	assign cnt_m1 = count_q - sras_pkg::CNT_W'(1);
	assign full   = (count_q == sras_pkg::CNT_W'(sras_pkg::MAX_ELEMENTS));
	assign span_ok = (lo_x <= hi_x) && (hi_x < cnt_x);
	assign at_x   = (lo_x > cnt_x) ? cnt_x : lo_x;

	always_comb begin
		dec_err  = sras_pkg::ERR_OK;
		dec_next = sras_pkg::ST_FINISH;
		dec_ptr  = lo_x[sras_pkg::ADDR_W-1:0];
		dec_end  = hi_x[sras_pkg::ADDR_W-1:0];
		case (in_data.kind)
			sras_pkg::KIND_INSERT: begin
				// Shift from the top element down to the insert point
				dec_ptr = cnt_m1[sras_pkg::ADDR_W-1:0];
				dec_end = at_x[sras_pkg::ADDR_W-1:0];
				if (full) begin
					dec_err = sras_pkg::ERR_FULL;
				end else if (at_x == cnt_x) begin
					dec_next = sras_pkg::ST_PUT;
				end else begin
					dec_next = sras_pkg::ST_WALK;
				end
			end
			sras_pkg::KIND_ADD, sras_pkg::KIND_SUM: begin
				if (span_ok) begin
					dec_next = sras_pkg::ST_WALK;
				end else begin
					dec_err = sras_pkg::ERR_SPAN;
				end
			end
			default: begin
				dec_err = sras_pkg::ERR_SPAN;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sras_pkg::ST_IDLE: begin
				if (in_valid) state_d = dec_next;
			end
			sras_pkg::ST_WALK: begin
				if (ptr_q == end_q) state_d = sras_pkg::ST_DRAIN;
			end
			sras_pkg::ST_DRAIN: begin
				state_d = (kind_q == sras_pkg::KIND_INSERT) ?
					sras_pkg::ST_PUT : sras_pkg::ST_FINISH;
			end
			sras_pkg::ST_PUT: begin
				state_d = sras_pkg::ST_FINISH;
			end
			sras_pkg::ST_FINISH: begin
				if (out_free) state_d = sras_pkg::ST_IDLE;
			end
			default: begin
				state_d = sras_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake, store access, result
	always_comb begin
		in_ready      = (state_q == sras_pkg::ST_IDLE);
		mem_req       = '0;
		res.valid     = (state_q == sras_pkg::ST_FINISH) && out_free;
		res.total     = total_q;
		res.err       = err_q;
		case (state_q)
			sras_pkg::ST_WALK: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = ptr_q;
			end
			sras_pkg::ST_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = end_q;
				mem_req.wdata = val_q;
			end
			default: begin
			end
		endcase
		// Write back the element read in the cycle before
		if (v_s1 && (kind_q != sras_pkg::KIND_SUM)) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = addr_s1;
			mem_req.wdata = (kind_q == sras_pkg::KIND_ADD) ? (mem_rdata + val_q) : mem_rdata;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sras_pkg::ST_IDLE;
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == sras_pkg::ST_WALK);
			if (state_q == sras_pkg::ST_PUT) begin
				count_q <= count_q + sras_pkg::CNT_W'(1);
			end
		end
	end

	// Request, walk pointer and accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_data.kind;
			val_q   <= in_data.operand_value;
			err_q   <= dec_err;
			total_q <= '0;
			ptr_q   <= dec_ptr;
			end_q   <= dec_end;
		end else begin
			if (state_q == sras_pkg::ST_WALK) begin
				ptr_q <= (kind_q == sras_pkg::KIND_INSERT) ?
					ptr_q - sras_pkg::ADDR_W'(1) : ptr_q + sras_pkg::ADDR_W'(1);
			end
			if (v_s1 && (kind_q == sras_pkg::KIND_SUM)) begin
				total_q <= total_q + mem_rdata;
			end
		end
		addr_s1 <= (kind_q == sras_pkg::KIND_INSERT) ? ptr_q + sras_pkg::ADDR_W'(1) : ptr_q;
	end

	// The element count never exceeds the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sras_pkg::CNT_W'(sras_pkg::MAX_ELEMENTS))
		else $error("element count beyond store size");

	// A write never hits the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr)))
		else $error("store read and write collide");

	// Placing an element grows the count by exactly one
	a_put_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sras_pkg::ST_PUT) |=>
			(count_q == $past(count_q) + sras_pkg::CNT_W'(1)))
		else $error("insert did not grow the count");

	// Write-back stage follows a walk cycle
	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ($past(state_q) == sras_pkg::ST_WALK))
		else $error("write-back stage without a read");

	// A result leaves only after the last write-back has drained
	a_res_drained: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !v_s1)
		else $error("result issued with a write-back pending");

endmodule

FILE: hdl/sequence_range_add_range_sum_unit.sv
// ----------------------------------------------------------------------------
// sequence_range_add_range_sum_unit: ordered value store with range ops
// Keeps an ordered sequence of signed 32-bit values in one on-chip RAM and
// serves positional insert, range add and range sum requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready as one in_t per transfer; each gives
//   exactly one out_t on out_valid/out_ready, in request order.
//   The unit handles one request at a time and walks the RAM one element per
//   cycle through a read/write-back pipeline (one read port, one write port):
//     range add / range sum over a span    : WALK, DRAIN, FINISH
//     insert that shifts elements          : WALK, DRAIN, PUT, FINISH
//     insert at or past the end (append)   : PUT, FINISH
//     rejected request (full store, bad span or unknown kind) : FINISH
//   in_ready rises again in the cycle after the result is handed to the
//   output register, so the next request is only taken once the last one
//   is through.
//   The output register holds a result while the receiver stalls; the next
//   request is still accepted and runs, and its result waits until the
//   held one is taken.
//   Reset empties the sequence at once (count cleared, no RAM sweep); RAM
//   entries are only read after they were written.
// ----------------------------------------------------------------------------
module sequence_range_add_range_sum_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sras_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sras_pkg::out_t out_data
);

	sras_pkg::mem_req_t            mem_req;
	logic [sras_pkg::DATA_W-1:0]   mem_rdata;
	sras_pkg::res_t                res;
	logic                          out_free;
	logic                          out_valid_q;
	sras_pkg::out_t                out_q;

	// Element store
	sras_ram #(
		.WIDTH(sras_pkg::DATA_W),
		.DEPTH(sras_pkg::MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Request sequencer
	sras_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.out_free  (out_free),
		.res       (res)
	);

	// Output register: free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q.range_total <= res.total;
			out_q.error_code  <= res.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: bench/sequence_range_add_range_sum_checker.sv
// ----------------------------------------------------------------------------
// sequence_range_add_range_sum_checker: result predictor and comparator
// Watches both channels of the sequence unit. Every accepted request is run
// through a private copy of the sequence to work out its answer; every
// accepted result is compared against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module sequence_range_add_range_sum_checker
	import sras_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_ready,
	input  in_t   in_data,
	input  logic  out_valid,
	input  logic  out_ready,
	input  out_t  out_data,
	output int    mismatch_count,
	output int    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// Private copy of the sequence
	logic [DATA_W-1:0] seq_vals [MAX_ELEMENTS];
	int                seq_len;

	// Answers still owed by the unit, oldest first
	out_t pending_answers [$];
	int   result_index;

	// Apply one request to the private sequence and return its answer
	function automatic out_t apply_request(in_t req);
		out_t              res;
		int                lo;
		int                hi;
		int                at;
		int                i;
		logic [DATA_W-1:0] acc;
		res.range_total = '0;
		res.error_code  = ERR_OK;
		lo  = int'(req.first_position);
		hi  = int'(req.last_position);
		acc = '0;
		case (req.kind)
			KIND_INSERT: begin
				if (seq_len >= MAX_ELEMENTS) begin
					res.error_code = ERR_FULL;
				end else begin
					// clamp past-the-end positions to an append
					at = (lo > seq_len) ? seq_len : lo;
					for (i = seq_len; i > at; i--)
						seq_vals[i] = seq_vals[i-1];
					seq_vals[at] = req.operand_value;
					seq_len++;
				end
			end
			KIND_ADD, KIND_SUM: begin
				if (lo > hi || hi >= seq_len) begin
					res.error_code = ERR_SPAN;
				end else if (req.kind == KIND_ADD) begin
					for (i = lo; i <= hi; i++)
						seq_vals[i] = seq_vals[i] + req.operand_value;
				end else begin
					for (i = lo; i <= hi; i++)
						acc = acc + seq_vals[i];
					res.range_total = acc;
				end
			end
			default: begin
				res.error_code = ERR_SPAN;
			end
		endcase
		return res;
	endfunction

	initial begin
		mismatch_count = 0;
		pending_count  = 0;
		seq_len        = 0;
		result_index   = 0;
	end

	// Predict on every request transfer, compare on every result transfer
	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			seq_len = 0;
			pending_answers.delete();
			pending_count = 0;
		end else begin
			if (in_valid && in_ready)
				pending_answers.push_back(apply_request(in_data));
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("[%0t] result %0d arrived with nothing outstanding: total %h error %0d",
							$realtime, result_index, out_data.range_total, out_data.error_code);
					mismatch_count++;
				end else begin
					want = pending_answers.pop_front();
					if (out_data.range_total !== want.range_total ||
						out_data.error_code !== want.error_code) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("[%0t] result %0d mismatch: total exp %h got %h, error exp %0d got %0d",
								$realtime, result_index, want.range_total, out_data.range_total,
								want.error_code, out_data.error_code);
						mismatch_count++;
					end
				end
				result_index++;
			end
			pending_count = pending_answers.size();
		end
	end

endmodule

FILE: bench/sequence_range_add_range_sum_unit_test.sv
// ----------------------------------------------------------------------------
// sequence_range_add_range_sum_unit_test: stimulus and verdict
// Drives insert, range add, range sum and unknown-kind requests into the
// sequence unit: a directed opening on a tiny sequence, then random phases
// that grow the sequence until the store is full and keep working on it.
// Both sides idle at random; the receiver also holds off for long stretches
// to back up the unit. Its checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sequence_range_add_range_sum_unit_test;
	import sras_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD   = 4.0;
	localparam int  RESET_CYCLES = 8;
	// Watchdog limit on the whole run, in ns
	localparam real RUN_LIMIT    = 4_000_000.0;
	localparam int  SETTLE_CYCLES = 32;
	localparam int  LONG_HOLD     = 1500;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int mismatch_count;
	int pending_count;

	// Sequence length as seen by the stimulus, used to aim spans and inserts
	int len_track     = 0;
	int sent_count    = 0;
	bit sender_quiet  = 1'b0;
	int taken_count   = 0;
	bit receiver_quiet = 1'b0;

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	sequence_range_add_range_sum_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	sequence_range_add_range_sum_checker u_result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// Mostly random words, sometimes the extremes
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(4, 0) != 0)
			return $urandom();
		case ($urandom_range(4, 0))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic in_t make_request(logic [KIND_W-1:0] kind, int lo, int hi,
		logic [DATA_W-1:0] val);
		in_t req;
		req.kind           = kind;
		req.first_position = lo[FIRST_W-1:0];
		req.last_position  = hi[LAST_W-1:0];
		req.operand_value  = val;
		return req;
	endfunction

	// Random request aimed at the current length; percentages pick the kind
	function automatic in_t random_request(int ins_pct, int add_pct, int sum_pct);
		int               roll;
		int               mode;
		int               lo;
		int               hi;
		logic [KIND_W-1:0] kind;
		roll = $urandom_range(99, 0);
		mode = $urandom_range(99, 0);
		if (roll < ins_pct) begin
			kind = KIND_INSERT;
			hi   = $urandom_range(1023, 0);
			// keep shifts short most of the time
			if (mode < 70)
				lo = $urandom_range(len_track, (len_track > 16) ? len_track - 16 : 0);
			else if (mode < 95)
				lo = $urandom_range(2047, len_track);
			else
				lo = $urandom_range(len_track, 0);
		end else if (roll < ins_pct + add_pct + sum_pct) begin
			kind = (roll < ins_pct + add_pct) ? KIND_ADD : KIND_SUM;
			if (len_track == 0 || mode < 8) begin
				// broken span: past the end or reversed
				if (len_track < MAX_ELEMENTS && $urandom_range(1, 0) == 1) begin
					hi = $urandom_range(1023, len_track);
					lo = $urandom_range(2047, 0);
				end else begin
					hi = $urandom_range(1023, 0);
					lo = $urandom_range(2047, hi + 1);
				end
			end else if (mode < 11) begin
				// nearly the whole sequence
				lo = $urandom_range((len_track > 4) ? 3 : len_track - 1, 0);
				hi = $urandom_range(len_track - 1, (len_track - 4 > lo) ? len_track - 4 : lo);
			end else begin
				lo = $urandom_range(len_track - 1, 0);
				hi = lo + $urandom_range(31, 0);
				if (hi > len_track - 1)
					hi = len_track - 1;
			end
		end else begin
			kind = KIND_UNKNOWN;
			lo   = $urandom_range(2047, 0);
			hi   = $urandom_range(1023, 0);
		end
		return make_request(kind, lo, hi, pick_value());
	endfunction

	// Offer one request after a random gap and hold it until the transfer
	task automatic send_request(input in_t req);
		int gap;
		if (sent_count % 50 == 0)
			sender_quiet = ($urandom_range(3, 0) == 0);
		gap = sender_quiet ? 0 : $urandom_range(4, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		if (req.kind == KIND_INSERT && len_track < MAX_ELEMENTS)
			len_track++;
		sent_count++;
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
	endtask

	// Receiver: random stalls per result, two long hold-offs to back up the unit
	initial begin : receiver
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken_count % 64 == 0)
				receiver_quiet = ($urandom_range(3, 0) == 0);
			stall = receiver_quiet ? 0 : $urandom_range(4, 0);
			if (taken_count == 150 || taken_count == 700)
				stall = LONG_HOLD;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken_count++;
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, extremes, inserts at front, middle and past the end
		send_request(make_request(KIND_SUM, 0, 0, 32'h0));
		send_request(make_request(KIND_ADD, 0, 0, 32'h1));
		send_request(make_request(KIND_INSERT, 0, 0, 32'h7FFF_FFFF));
		send_request(make_request(KIND_INSERT, 2047, 1023, 32'h8000_0000));
		send_request(make_request(KIND_INSERT, 1, 0, 32'hFFFF_FFFF));
		send_request(make_request(KIND_INSERT, 0, 1023, 32'h0000_0001));
		send_request(make_request(KIND_INSERT, 1024, 0, 32'h0));
		send_request(make_request(KIND_SUM, 0, 4, 32'h0));
		send_request(make_request(KIND_SUM, 0, 0, 32'hFFFF_FFFF));
		send_request(make_request(KIND_SUM, 4, 4, 32'h0));
		send_request(make_request(KIND_ADD, 0, 4, 32'h7FFF_FFFF));
		send_request(make_request(KIND_SUM, 0, 4, 32'h0));
		send_request(make_request(KIND_ADD, 2, 2, 32'h8000_0000));
		send_request(make_request(KIND_SUM, 1, 3, 32'h0));
		// reversed span, span one past the end, far positions
		send_request(make_request(KIND_SUM, 3, 2, 32'h0));
		send_request(make_request(KIND_SUM, 0, 5, 32'h0));
		send_request(make_request(KIND_ADD, 2047, 1023, 32'hFFFF_FFFF));
		send_request(make_request(KIND_SUM, 0, 1023, 32'h0));
		// unknown kind with all-ones and all-zeros fields
		send_request(make_request(KIND_UNKNOWN, 2047, 1023, 32'hFFFF_FFFF));
		send_request(make_request(KIND_UNKNOWN, 0, 0, 32'h0));
		send_request(make_request(KIND_ADD, 0, 0, 32'h0));
		send_request(make_request(KIND_SUM, 0, 4, 32'h0));
		wait_for_results();

		// Mixed traffic on a short sequence
		repeat (150) send_request(random_request(45, 25, 25));
		wait_for_results();

		// Grow the sequence until the store is full, then push into it
		while (len_track < MAX_ELEMENTS)
			send_request(random_request(85, 5, 7));
		repeat (30) send_request(random_request(60, 15, 20));
		wait_for_results();

		// Work on the full store
		repeat (150) send_request(random_request(20, 35, 35));
		wait_for_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("** sequence_range_add_range_sum_unit: PASSED **");
		end else begin
			$display("** sequence_range_add_range_sum_unit: FAILED **");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin : watchdog
		#(RUN_LIMIT);
		$display("** sequence_range_add_range_sum_unit: FAILED **");
		$finish;
	end

endmodule
